@@ src/nhfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nhfe_pkg
// Shared types and constants for the host frame encoder.
// ----------------------------------------------------------------------------
package nhfe_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD = 8'd254;

    // byte kinds, encoded as on the output port
    typedef enum logic [3:0] {
        KIND_PREAMBLE   = 4'd0,
        KIND_START1     = 4'd1,
        KIND_START2     = 4'd2,
        KIND_LENGTH     = 4'd3,
        KIND_LEN_CHECK  = 4'd4,
        KIND_DIRECTION  = 4'd5,
        KIND_PAYLOAD    = 4'd6,
        KIND_DATA_CHECK = 4'd7,
        KIND_POSTAMBLE  = 4'd8
    } t_kind;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PREAMBLE   = 3'd0,
        REG_START1     = 3'd1,
        REG_START2     = 3'd2,
        REG_DIRECTION  = 3'd3,
        REG_POSTAMBLE  = 3'd4
    } t_reg_idx;

    localparam logic [BYTE_W-1:0] RST_PREAMBLE  = 8'h00;
    localparam logic [BYTE_W-1:0] RST_START1    = 8'h00;
    localparam logic [BYTE_W-1:0] RST_START2    = 8'hFF;
    localparam logic [BYTE_W-1:0] RST_DIRECTION = 8'hD4;
    localparam logic [BYTE_W-1:0] RST_POSTAMBLE = 8'h00;

    typedef struct packed {
        logic [BYTE_W-1:0] preamble;
        logic [BYTE_W-1:0] start1;
        logic [BYTE_W-1:0] start2;
        logic [BYTE_W-1:0] direction;
        logic [BYTE_W-1:0] postamble;
    } t_cfg;

endpackage

@@ src/nhfe_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nhfe_cfg_regs
// Configuration register bank: decodes the write channel into frame bytes.
// ----------------------------------------------------------------------------
module nhfe_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nhfe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nhfe_pkg::BYTE_W-1:0]   i_cfg_data,
    output nhfe_pkg::t_cfg                o_cfg
);

    nhfe_pkg::t_cfg r_cfg;
    nhfe_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (nhfe_pkg::t_reg_idx'(i_cfg_index))
                nhfe_pkg::REG_PREAMBLE:  n_cfg.preamble  = i_cfg_data;
                nhfe_pkg::REG_START1:    n_cfg.start1    = i_cfg_data;
                nhfe_pkg::REG_START2:    n_cfg.start2    = i_cfg_data;
                nhfe_pkg::REG_DIRECTION: n_cfg.direction = i_cfg_data;
                nhfe_pkg::REG_POSTAMBLE: n_cfg.postamble = i_cfg_data;
                default:                 n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preamble  <= nhfe_pkg::RST_PREAMBLE;
            r_cfg.start1    <= nhfe_pkg::RST_START1;
            r_cfg.start2    <= nhfe_pkg::RST_START2;
            r_cfg.direction <= nhfe_pkg::RST_DIRECTION;
            r_cfg.postamble <= nhfe_pkg::RST_POSTAMBLE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ src/nfc_host_frame_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_host_frame_encoder
// Wraps payload bytes in host-to-reader information frames.
// ----------------------------------------------------------------------------
// Items wait in the item register, results in the result register.
// Throughput: one result byte per cycle unless the output stalls. An item
// yields 1 result as a mid-frame byte, up to 9 as a one-byte frame, holds the
// input until its last is issued, and the next item is taken in that cycle.
// Reset (synchronous, active low): idle between frames, sum and count zero,
// registers at their defaults, no item held and no result pending.
module nfc_host_frame_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input item channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [nhfe_pkg::BYTE_W-1:0]   i_payload_byte,
    input  logic [nhfe_pkg::BYTE_W-1:0]   i_payload_count,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [nhfe_pkg::BYTE_W-1:0]   o_frame_byte,
    output logic [3:0]                    o_byte_kind,
    output logic                          o_run_last,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nhfe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nhfe_pkg::BYTE_W-1:0]   i_cfg_data
);

    nhfe_pkg::t_cfg cfg;

    nhfe_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // held input item
    logic                        r_item_valid;
    logic [nhfe_pkg::BYTE_W-1:0] r_byte;
    logic [nhfe_pkg::BYTE_W-1:0] r_count;
    nhfe_pkg::t_kind             r_kind;
    nhfe_pkg::t_kind             n_kind;

    // frame state
    logic                        r_in_frame;
    logic                        n_in_frame;
    logic [nhfe_pkg::BYTE_W-1:0] r_bytes_left;
    logic [nhfe_pkg::BYTE_W-1:0] n_bytes_left;
    logic [nhfe_pkg::BYTE_W-1:0] r_data_sum;
    logic [nhfe_pkg::BYTE_W-1:0] n_data_sum;

    // result register
    logic                        r_out_valid;
    logic [nhfe_pkg::BYTE_W-1:0] r_out_byte;
    nhfe_pkg::t_kind             r_out_kind;
    logic                        r_out_last;

    logic                        out_load;
    logic                        emit;
    logic                        item_done;
    logic                        in_take;
    logic [nhfe_pkg::BYTE_W-1:0] sat_count;
    logic [nhfe_pkg::BYTE_W-1:0] len_byte;
    logic [nhfe_pkg::BYTE_W-1:0] sum_with_byte;
    logic [nhfe_pkg::BYTE_W-1:0] left_dec;
    logic [nhfe_pkg::BYTE_W-1:0] emit_byte;
    logic                        emit_last;

    assign out_load  = !r_out_valid || !i_out_stall;
    assign emit      = r_item_valid && out_load;
    assign item_done = emit && emit_last;
    assign o_in_stall = r_item_valid && !item_done;
    assign in_take   = i_in_valid && !o_in_stall;

    // count saturated into 1..MAX_PAYLOAD
    always_comb begin
        if (r_count == '0) begin
            sat_count = nhfe_pkg::BYTE_W'(1);
        end else if (r_count > nhfe_pkg::MAX_PAYLOAD) begin
            sat_count = nhfe_pkg::MAX_PAYLOAD;
        end else begin
            sat_count = r_count;
        end
    end

    assign len_byte      = sat_count + nhfe_pkg::BYTE_W'(1);
    assign sum_with_byte = r_data_sum + r_byte;
    assign left_dec      = (r_bytes_left != '0) ? r_bytes_left - nhfe_pkg::BYTE_W'(1)
                                                : r_bytes_left;

    always_comb begin
        n_kind       = r_kind;
        n_in_frame   = r_in_frame;
        n_bytes_left = r_bytes_left;
        n_data_sum   = r_data_sum;
        emit_byte    = r_byte;
        emit_last    = 1'b0;
        unique case (r_kind)
            nhfe_pkg::KIND_PREAMBLE: begin
                emit_byte = cfg.preamble;
                n_kind    = nhfe_pkg::KIND_START1;
            end
            nhfe_pkg::KIND_START1: begin
                emit_byte = cfg.start1;
                n_kind    = nhfe_pkg::KIND_START2;
            end
            nhfe_pkg::KIND_START2: begin
                emit_byte = cfg.start2;
                n_kind    = nhfe_pkg::KIND_LENGTH;
            end
            nhfe_pkg::KIND_LENGTH: begin
                emit_byte = len_byte;
                n_kind    = nhfe_pkg::KIND_LEN_CHECK;
            end
            nhfe_pkg::KIND_LEN_CHECK: begin
                emit_byte = '0 - len_byte;
                n_kind    = nhfe_pkg::KIND_DIRECTION;
            end
            nhfe_pkg::KIND_DIRECTION: begin
                emit_byte    = cfg.direction;
                n_kind       = nhfe_pkg::KIND_PAYLOAD;
                n_data_sum   = cfg.direction;
                n_bytes_left = sat_count;
                n_in_frame   = 1'b1;
            end
            nhfe_pkg::KIND_PAYLOAD: begin
                emit_byte    = r_byte;
                n_data_sum   = sum_with_byte;
                n_bytes_left = left_dec;
                if (left_dec == '0) begin
                    n_kind = nhfe_pkg::KIND_DATA_CHECK;
                end else begin
                    emit_last = 1'b1;
                end
            end
            nhfe_pkg::KIND_DATA_CHECK: begin
                emit_byte = '0 - r_data_sum;
                n_kind    = nhfe_pkg::KIND_POSTAMBLE;
            end
            nhfe_pkg::KIND_POSTAMBLE: begin
                emit_byte  = cfg.postamble;
                emit_last  = 1'b1;
                n_in_frame = 1'b0;
            end
            default: begin
                emit_byte = r_byte;
                emit_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_kind       <= nhfe_pkg::KIND_PREAMBLE;
            r_in_frame   <= 1'b0;
            r_bytes_left <= '0;
            r_data_sum   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (emit) begin
                r_in_frame   <= n_in_frame;
                r_bytes_left <= n_bytes_left;
                r_data_sum   <= n_data_sum;
            end
            if (in_take) begin
                r_item_valid <= 1'b1;
                // a new item opens a frame unless one is still running
                r_kind <= (emit ? n_in_frame : r_in_frame) ? nhfe_pkg::KIND_PAYLOAD
                                                            : nhfe_pkg::KIND_PREAMBLE;
            end else if (item_done) begin
                r_item_valid <= 1'b0;
            end else if (emit) begin
                r_kind <= n_kind;
            end
            if (out_load) begin
                r_out_valid <= r_item_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte  <= i_payload_byte;
            r_count <= i_payload_count;
        end
        if (emit) begin
            r_out_byte <= emit_byte;
            r_out_kind <= r_kind;
            r_out_last <= emit_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_byte_kind  = r_out_kind;
    assign o_run_last   = r_out_last;

endmodule
